@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lms: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lms: next-cycle check failed");

`endif

@@ rtl/lms_pkg.sv @@
package lms_pkg;

	// default message store depth (columns)
	localparam int LMS_MSG_DEPTH = 256;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_DWELL_TICKS     = 2'd0;
	localparam cfg_idx_t REG_FRAMES_PER_STEP = 2'd1;
	localparam cfg_idx_t REG_MESSAGE_LENGTH  = 2'd2;
	localparam cfg_idx_t REG_SCROLL_ENABLE   = 2'd3;

	localparam int CFG_DATA_W = 16;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// register reset values
	localparam logic [15:0] DWELL_RST  = 16'd2500;
	localparam logic [7:0]  FRAMES_RST = 8'd15;
	localparam logic [8:0]  LENGTH_RST = 9'd8;
	localparam logic        SCROLL_RST = 1'b1;

	// window width in columns
	localparam logic [8:0] WINDOW_COLS = 9'd8;

	// item commands
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] column_index;
		logic [7:0] column_data;
	} item_t;

	typedef struct packed {
		logic [7:0] column_enable_n;
		logic [7:0] row_bits;
		logic       pass_done;
	} result_t;

endpackage

@@ rtl/lms_stream_if.sv @@
interface lms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/led_matrix_scroll_scanner.sv @@
// Channel   Dir  Payload                                        Transaction when
// item      in   command, column_index, column_data             item.valid & item.ready
// result    out  column_enable_n, row_bits, pass_done           result.valid & result.ready
// cfg       in   cfg_we, cfg_index, cfg_data (write only)       cfg_we high at clk edge
//
// One transaction per clock while result.ready is high and no clearing pass runs;
// the store has one write and one read port, and each item does one read plus at most one write.
// A result leaves through the store read stage, then the output register.
// After arst_n the store is cleared one entry per cycle, all MSG_DEPTH entries, with
// item.ready low; configuration writes are taken throughout.
// A stalled result holds in the output register; one more item can sit in the
// read stage before item.ready drops.
module led_matrix_scroll_scanner #(
	parameter int MSG_DEPTH = lms_pkg::LMS_MSG_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	lms_stream_if.sink         item,
	lms_stream_if.source       result,
	input  logic               cfg_we,
	input  lms_pkg::cfg_idx_t  cfg_index,
	input  lms_pkg::cfg_data_t cfg_data
);
	import lms_pkg::*;

	// store address width; IW holds a 9-bit value and MSG_DEPTH itself
	localparam int AW  = $clog2(MSG_DEPTH);
	localparam int IW  = (AW + 1 > 9) ? AW + 1 : 9;
	// longest usable message
	localparam int CAP = (MSG_DEPTH < 256) ? MSG_DEPTH : 256;

	typedef logic [AW-1:0] addr_t;

	// ---------------- configuration registers ----------------
	logic [15:0] dwell_ticks_q;
	logic [7:0]  frames_per_step_q;
	logic [8:0]  message_length_q;
	logic        scroll_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q     <= DWELL_RST;
			frames_per_step_q <= FRAMES_RST;
			message_length_q  <= LENGTH_RST;
			scroll_enable_q   <= SCROLL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DWELL_TICKS:     dwell_ticks_q     <= cfg_data;
				REG_FRAMES_PER_STEP: frames_per_step_q <= cfg_data[7:0];
				REG_MESSAGE_LENGTH:  message_length_q  <= cfg_data[8:0];
				REG_SCROLL_ENABLE:   scroll_enable_q   <= cfg_data[0];
			endcase
		end
	end

	// ---------------- scan counters ----------------
	logic [15:0] dwell_count_q;
	logic [2:0]  active_col_q;
	logic [7:0]  frame_count_q;
	logic [7:0]  scroll_off_q;

	// clearing pass state
	logic  clr_q;
	addr_t clr_idx_q;

	// pipeline control
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic accept;

	assign s1_adv     = s1_valid_q && (!out_valid_q || result.ready);
	assign item.ready = !clr_q && (!s1_valid_q || !out_valid_q || result.ready);
	assign accept     = item.valid && item.ready;

	// next-state values for the accepted item
	logic [15:0] dwell_eff;
	logic [7:0]  frames_eff;
	logic [8:0]  len_eff;
	logic [16:0] dwell_inc;
	logic [8:0]  frame_inc;
	logic [15:0] dwell_n;
	logic [2:0]  col_n;
	logic [7:0]  frame_n;
	logic [7:0]  off_n;
	logic        pass_n;
	logic [IW-1:0] rsum;
	logic [IW-1:0] widx;
	logic        wr_ok;
	addr_t       raddr;

	always_comb begin
		dwell_eff  = (dwell_ticks_q == 16'd0) ? 16'd1 : dwell_ticks_q;
		frames_eff = (frames_per_step_q == 8'd0) ? 8'd1 : frames_per_step_q;
		if (message_length_q < WINDOW_COLS)
			len_eff = WINDOW_COLS;
		else if (message_length_q > 9'(CAP))
			len_eff = 9'(CAP);
		else
			len_eff = message_length_q;

		dwell_inc = {1'b0, dwell_count_q} + 17'd1;
		frame_inc = {1'b0, frame_count_q} + 9'd1;
		dwell_n   = dwell_count_q;
		col_n     = active_col_q;
		frame_n   = frame_count_q;
		off_n     = scroll_off_q;
		pass_n    = 1'b0;

		if (item.data.command == CMD_TICK) begin
			if (dwell_inc < {1'b0, dwell_eff}) begin
				dwell_n = dwell_inc[15:0];
			end else begin
				dwell_n = 16'd0;
				col_n   = active_col_q + 3'd1;
				// frame completes when column wraps to 0
				if (active_col_q == 3'd7) begin
					if (frame_inc < {1'b0, frames_eff}) begin
						frame_n = frame_inc[7:0];
					end else begin
						frame_n = 8'd0;
						// scroll step
						if (!scroll_enable_q || len_eff <= WINDOW_COLS) begin
							off_n = 8'd0;
						end else if ({1'b0, scroll_off_q} >= len_eff - WINDOW_COLS) begin
							off_n  = 8'd0;
							pass_n = 1'b1;
						end else begin
							off_n = scroll_off_q + 8'd1;
						end
					end
				end
			end
		end

		// read address, reduced modulo the depth
		rsum = IW'(off_n) + IW'(col_n);
		if (rsum >= IW'(MSG_DEPTH))
			rsum = rsum - IW'(MSG_DEPTH);
		raddr = rsum[AW-1:0];

		// writes beyond the store are dropped
		widx  = IW'(item.data.column_index);
		wr_ok = (item.data.command == CMD_WRITE) && (widx < IW'(MSG_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_count_q <= '0;
			active_col_q  <= '0;
			frame_count_q <= '0;
			scroll_off_q  <= '0;
		end else if (accept) begin
			dwell_count_q <= dwell_n;
			active_col_q  <= col_n;
			frame_count_q <= frame_n;
			scroll_off_q  <= off_n;
		end
	end

	// ---------------- clearing pass ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(MSG_DEPTH - 1))
				clr_q <= 1'b0;
			else
				clr_idx_q <= clr_idx_q + addr_t'(1);
		end
	end

	// ---------------- message store ----------------
	logic [7:0] store_mem [MSG_DEPTH];
	logic       mem_we;
	addr_t      mem_waddr;
	logic [7:0] mem_wdata;

	assign mem_we    = clr_q || (accept && wr_ok);
	assign mem_waddr = clr_q ? clr_idx_q : widx[AW-1:0];
	assign mem_wdata = clr_q ? 8'd0 : item.data.column_data;

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_waddr] <= mem_wdata;
	end

	logic [7:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (accept)
			rdata_s1 <= store_mem[raddr];
	end

	// ---------------- read stage (s1) ----------------
	// a write to the entry read in the same cycle is forwarded
	logic [7:0] col_en_n_s1;
	logic       pass_s1;
	logic       fwd_s1;
	logic [7:0] fwd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_en_n_s1 <= 8'hFF ^ (8'd1 << col_n);
			pass_s1     <= pass_n;
			fwd_s1      <= wr_ok && (widx[AW-1:0] == raddr);
			fwd_data_s1 <= item.data.column_data;
		end
	end

	// ---------------- output register ----------------
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.column_enable_n <= col_en_n_s1;
			out_q.row_bits        <= fwd_s1 ? fwd_data_s1 : rdata_s1;
			out_q.pass_done       <= pass_s1;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

@@ rtl/lms_checker.sv @@
`include "assert_macros.svh"

module lms_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input lms_pkg::result_t result_data
);
	import lms_pkg::*;

	// exactly one column lit in every result
	`LMS_ASSERT_IMPLY(a_one_cold, clk, arst_n, result_valid, $countones(result_data.column_enable_n) == 7)

	// the scroll wraps only as a frame restarts at column 0
	`LMS_ASSERT_IMPLY(a_pass_col0, clk, arst_n, result_valid && result_data.pass_done, result_data.column_enable_n == 8'hFE)

	// a stalled result stays offered
	`LMS_ASSERT_NEXT(a_hold_valid, clk, arst_n, result_valid && !result_ready, result_valid)

	// and keeps its payload
	`LMS_ASSERT_NEXT(a_hold_data, clk, arst_n, result_valid && !result_ready, $stable(result_data))

endmodule

bind led_matrix_scroll_scanner lms_checker u_lms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
